/* rtl/gif_screen_header_parser_defines.svh */
// ----------------------------------------------------------------------------
// GIF screen header parser: assertion macros
// Shared property wrappers; they compile to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef GIF_SCREEN_HEADER_PARSER_DEFINES_SVH
`define GIF_SCREEN_HEADER_PARSER_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication
`define GSH_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gsh: same-cycle check failed");

// next-cycle implication
`define GSH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gsh: next-cycle check failed");

`else

`define GSH_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define GSH_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/gsh_pkg.sv */
// ----------------------------------------------------------------------------
// GIF screen header parser package
// Word types for both channels and the result kind codes.
// ----------------------------------------------------------------------------
package gsh_pkg;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_COLOR   = 2'd1,
    KIND_BAD_SIG = 2'd2,
    KIND_EOF     = 2'd3
  } gsh_kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
    logic       begin_file;
  } gsh_in_t;

  typedef struct packed {
    gsh_kind_e   result_kind;
    logic        last_of_file;
    logic [23:0] version_text;
    logic [15:0] screen_width;
    logic [15:0] screen_height;
    logic [8:0]  table_entries;
    logic        table_sorted;
    logic [8:0]  color_levels;
    logic [7:0]  background_index;
    logic [7:0]  aspect_byte;
    logic [31:0] color_word;
    logic [7:0]  entry_index;
  } gsh_out_t;

endpackage

/* rtl/gsh_parse_core.sv */
// ----------------------------------------------------------------------------
// GIF screen header parser: parse core
// Holds the parse state and turns one accepted byte into at most one result.
// ----------------------------------------------------------------------------
`include "gif_screen_header_parser_defines.svh"

module gsh_parse_core
  import gsh_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     acc_i,
  input  gsh_in_t  in_i,
  output logic     res_valid_o,
  output gsh_out_t res_o
);

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_TABLE  = 3'b010,
    PH_DONE   = 3'b100
  } gsh_phase_e;

  localparam logic [3:0] POS_VER_FIRST = 4'd3;
  localparam logic [3:0] POS_WIDTH_LO  = 4'd6;
  localparam logic [3:0] POS_WIDTH_HI  = 4'd7;
  localparam logic [3:0] POS_HEIGHT_LO = 4'd8;
  localparam logic [3:0] POS_HEIGHT_HI = 4'd9;
  localparam logic [3:0] POS_PACKED    = 4'd10;
  localparam logic [3:0] POS_BG        = 4'd11;
  localparam logic [3:0] POS_ASPECT    = 4'd12;
  localparam logic [3:0] POS_PAST_HDR  = 4'd13;
  localparam logic [7:0] ALPHA_BYTE    = 8'hFF;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  function automatic logic [7:0] sig_byte(input logic [1:0] idx);
    logic [7:0] v;
    case (idx)
      2'd0:    v = 8'h47;
      2'd1:    v = 8'h49;
      default: v = 8'h46;
    endcase
    return v;
  endfunction

  function automatic logic [8:0] table_size(input logic [7:0] pk);
    return pk[7] ? (9'd2 << pk[2:0]) : 9'd0;
  endfunction

  gsh_phase_e  phase_q, phase_d, phase_e;
  logic [3:0]  pos_q, pos_d, pos_e;
  logic [23:0] ver_q, ver_d, ver_e;
  logic [15:0] wid_q, wid_d, wid_e;
  logic [15:0] hgt_q, hgt_d, hgt_e;
  logic [7:0]  pk_q, pk_d, pk_e;
  logic [7:0]  bg_q, bg_d, bg_e;
  logic [8:0]  cnt_q, cnt_d, cnt_e;
  logic [15:0] part_q, part_d, part_e;
  logic [1:0]  ch_q, ch_d, ch_e;
  logic [8:0]  tab_n;
  logic [8:0]  cnt_inc;
  logic [7:0]  b;

  assign b       = in_i.data_byte;
  assign tab_n   = table_size(pk_e);
  assign cnt_inc = cnt_e + 9'd1;

  always_comb begin
    // restart clears the parse state before the byte is looked at
    phase_e = phase_q;
    pos_e   = pos_q;
    ver_e   = ver_q;
    wid_e   = wid_q;
    hgt_e   = hgt_q;
    pk_e    = pk_q;
    bg_e    = bg_q;
    cnt_e   = cnt_q;
    part_e  = part_q;
    ch_e    = ch_q;
    if (acc_i && in_i.begin_file) begin
      phase_e = PH_HEADER;
      pos_e   = '0;
      ver_e   = '0;
      wid_e   = '0;
      hgt_e   = '0;
      pk_e    = '0;
      bg_e    = '0;
      cnt_e   = '0;
      part_e  = '0;
      ch_e    = '0;
    end
  end

  always_comb begin
    phase_d     = phase_e;
    pos_d       = pos_e;
    ver_d       = ver_e;
    wid_d       = wid_e;
    hgt_d       = hgt_e;
    pk_d        = pk_e;
    bg_d        = bg_e;
    cnt_d       = cnt_e;
    part_d      = part_e;
    ch_d        = ch_e;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.result_kind = KIND_HEADER;

    if (acc_i) begin
      if (phase_e == PH_HEADER && pos_e >= POS_PAST_HDR) begin
        phase_d = PH_DONE;
      end else if (phase_e == PH_HEADER || phase_e == PH_TABLE) begin
        if (in_i.end_of_file) begin
          res_valid_o        = 1'b1;
          res_o.result_kind  = KIND_EOF;
          res_o.last_of_file = 1'b1;
          phase_d            = PH_DONE;
        end else if (phase_e == PH_HEADER) begin
          pos_d = pos_e + 4'd1;
          if (pos_e < POS_VER_FIRST) begin
            if (b != sig_byte(pos_e[1:0])) begin
              res_valid_o        = 1'b1;
              res_o.result_kind  = KIND_BAD_SIG;
              res_o.last_of_file = 1'b1;
              phase_d            = PH_DONE;
              pos_d              = pos_e;
            end
          end else if (pos_e < POS_WIDTH_LO) begin
            ver_d = {ver_e[15:0], b};
          end else if (pos_e == POS_WIDTH_LO) begin
            wid_d = {8'h00, b};
          end else if (pos_e == POS_WIDTH_HI) begin
            wid_d = {b, wid_e[7:0]};
          end else if (pos_e == POS_HEIGHT_LO) begin
            hgt_d = {8'h00, b};
          end else if (pos_e == POS_HEIGHT_HI) begin
            hgt_d = {b, hgt_e[7:0]};
          end else if (pos_e == POS_PACKED) begin
            pk_d = b;
          end else if (pos_e == POS_BG) begin
            bg_d = b;
          end else begin
            // aspect byte closes the descriptor
            res_valid_o            = 1'b1;
            res_o.result_kind      = KIND_HEADER;
            res_o.last_of_file     = (tab_n == 9'd0);
            res_o.version_text     = ver_e;
            res_o.screen_width     = wid_e;
            res_o.screen_height    = hgt_e;
            res_o.table_entries    = tab_n;
            res_o.table_sorted     = pk_e[3];
            res_o.color_levels     = 9'd2 << pk_e[6:4];
            res_o.background_index = bg_e;
            res_o.aspect_byte      = b;
            pos_d                  = POS_PAST_HDR;
            cnt_d                  = '0;
            ch_d                   = CH_RED;
            part_d                 = '0;
            phase_d                = (tab_n == 9'd0) ? PH_DONE : PH_TABLE;
          end
        end else begin
          case (ch_e)
            CH_RED: begin
              part_d = {8'h00, b};
              ch_d   = CH_GREEN;
            end
            CH_GREEN: begin
              part_d = {part_e[7:0], b};
              ch_d   = CH_BLUE;
            end
            default: begin
              res_valid_o       = 1'b1;
              res_o.result_kind = KIND_COLOR;
              res_o.color_word  = {part_e, b, ALPHA_BYTE};
              res_o.entry_index = cnt_e[7:0];
              cnt_d             = cnt_inc;
              ch_d              = CH_RED;
              part_d            = '0;
              if (cnt_inc >= tab_n) begin
                res_o.last_of_file = 1'b1;
                phase_d            = PH_DONE;
              end
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      pos_q   <= '0;
      ver_q   <= '0;
      wid_q   <= '0;
      hgt_q   <= '0;
      pk_q    <= '0;
      bg_q    <= '0;
      cnt_q   <= '0;
      part_q  <= '0;
      ch_q    <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      ver_q   <= ver_d;
      wid_q   <= wid_d;
      hgt_q   <= hgt_d;
      pk_q    <= pk_d;
      bg_q    <= bg_d;
      cnt_q   <= cnt_d;
      part_q  <= part_d;
      ch_q    <= ch_d;
    end
  end

  `GSH_ASSERT_NEXT(a_last_ends_parse, clk_i, rst_ni,
    acc_i && res_valid_o && res_o.last_of_file, phase_q == PH_DONE)
  `GSH_ASSERT_IMPLY(a_table_count_in_range, clk_i, rst_ni,
    phase_q == PH_TABLE, cnt_q < table_size(pk_q))
  `GSH_ASSERT_IMPLY(a_channel_in_range, clk_i, rst_ni,
    1'b1, ch_q != 2'd3)

endmodule

/* rtl/gsh_out_skid.sv */
// ----------------------------------------------------------------------------
// GIF screen header parser: output register with skid stage
// Two-deep result buffer; input side stalls only when both slots hold words.
// ----------------------------------------------------------------------------
`include "gif_screen_header_parser_defines.svh"

module gsh_out_skid
  import gsh_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  gsh_out_t push_data_i,
  output logic     can_push_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output gsh_out_t out_data_o
);

  logic     out_valid_q, out_valid_d;
  logic     skid_valid_q, skid_valid_d;
  gsh_out_t out_q, out_d;
  gsh_out_t skid_q, skid_d;
  logic     pop;

  assign pop         = out_valid_q && out_ready_i;
  assign can_push_o  = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (pop) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = push_i;
        out_d       = push_data_i;
      end
    end else if (!out_valid_q) begin
      out_valid_d = push_i;
      out_d       = push_data_i;
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_d       = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  `GSH_ASSERT_IMPLY(a_skid_behind_out, clk_i, rst_ni,
    skid_valid_q, out_valid_q)
  `GSH_ASSERT_NEXT(a_push_on_stall_fills_skid, clk_i, rst_ni,
    push_i && out_valid_q && !out_ready_i, skid_valid_q)
  `GSH_ASSERT_NEXT(a_skid_drains_to_out, clk_i, rst_ni,
    skid_valid_q && out_ready_i, out_valid_q && !skid_valid_q)

endmodule

/* rtl/gif_screen_header_parser.sv */
// ----------------------------------------------------------------------------
// GIF screen header parser
// Byte-stream parser for the GIF signature, logical screen descriptor and
// global color table; one header word, one word per color entry, or an error.
// ----------------------------------------------------------------------------
//
//  channel | handshake             | word type  | carries
//  --------+-----------------------+------------+------------------------------
//  in      | in_valid_i/in_ready_o | gsh_in_t   | file byte, end/begin marks
//  out     | out_valid_o/out_ready_i | gsh_out_t | header, color entry, error
//
//  One byte per cycle while the skid slot is free; each byte updates the
//  parse state in the cycle it is accepted, and its result word (if any) is
//  registered there. That word shows on out the next cycle unless an older
//  word still waits, in which case it sits in the skid slot behind it.
//  in_ready_o drops only while the skid slot is full. Reset puts the parser
//  at the first signature byte and empties both slots.
//
module gif_screen_header_parser
  import gsh_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  // byte input
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  gsh_in_t  in_data_i,
  // result output
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output gsh_out_t out_data_o
);

  logic     acc;
  logic     res_valid;
  gsh_out_t res;
  logic     can_push;

  // a byte is taken whenever the skid slot is free
  assign in_ready_o = can_push;
  assign acc        = in_valid_i && can_push;

  // parse state and per-byte decode
  gsh_parse_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .in_i        (in_data_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result register and skid slot
  gsh_out_skid u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .can_push_o  (can_push),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
